>>> rtl/core/chv_pkg.sv
// Package for the cartridge header validator: offsets, codes and lookup tables.
package chv_pkg;

    localparam int unsigned OFFSET_W = 9;
    localparam int unsigned BYTE_W   = 8;

    localparam logic [OFFSET_W-1:0] LOGO_START = 9'h104;
    localparam logic [OFFSET_W-1:0] LOGO_END   = 9'h133;
    localparam logic [OFFSET_W-1:0] SUM_START  = 9'h134;
    localparam logic [OFFSET_W-1:0] TYPE_AT    = 9'h147;
    localparam logic [OFFSET_W-1:0] REGION_AT  = 9'h14a;
    localparam logic [OFFSET_W-1:0] VERSION_AT = 9'h14c;
    localparam logic [OFFSET_W-1:0] STORED_AT  = 9'h14d;

    typedef enum logic [1:0] {
        ST_VALID    = 2'd0,
        ST_BAD_LOGO = 2'd1,
        ST_BAD_TYPE = 2'd2,
        ST_BAD_SUM  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        MK_PLAIN = 3'd0,
        MK_MBC1  = 3'd1,
        MK_MBC2  = 3'd2,
        MK_MMM01 = 3'd3,
        MK_MBC3  = 3'd4,
        MK_MBC5  = 3'd5
    } mapper_kind_t;

    typedef struct packed {
        logic         ok;
        mapper_kind_t kind;
    } type_lookup_t;

    function automatic logic [BYTE_W-1:0] logo_byte(input logic [5:0] idx);
        logic [BYTE_W-1:0] b;
        case (idx)
            6'd0:  b = 8'hce;  6'd1:  b = 8'hed;  6'd2:  b = 8'h66;  6'd3:  b = 8'h66;
            6'd4:  b = 8'hcc;  6'd5:  b = 8'h0d;  6'd6:  b = 8'h00;  6'd7:  b = 8'h0b;
            6'd8:  b = 8'h03;  6'd9:  b = 8'h73;  6'd10: b = 8'h00;  6'd11: b = 8'h83;
            6'd12: b = 8'h00;  6'd13: b = 8'h0c;  6'd14: b = 8'h00;  6'd15: b = 8'h0d;
            6'd16: b = 8'h00;  6'd17: b = 8'h08;  6'd18: b = 8'h11;  6'd19: b = 8'h1f;
            6'd20: b = 8'h88;  6'd21: b = 8'h89;  6'd22: b = 8'h00;  6'd23: b = 8'h0e;
            6'd24: b = 8'hdc;  6'd25: b = 8'hcc;  6'd26: b = 8'h6e;  6'd27: b = 8'he6;
            6'd28: b = 8'hdd;  6'd29: b = 8'hdd;  6'd30: b = 8'hd9;  6'd31: b = 8'h99;
            6'd32: b = 8'hbb;  6'd33: b = 8'hbb;  6'd34: b = 8'h67;  6'd35: b = 8'h63;
            6'd36: b = 8'h6e;  6'd37: b = 8'h0e;  6'd38: b = 8'hec;  6'd39: b = 8'hcc;
            6'd40: b = 8'hdd;  6'd41: b = 8'hdc;  6'd42: b = 8'h99;  6'd43: b = 8'h9f;
            6'd44: b = 8'hbb;  6'd45: b = 8'hb9;  6'd46: b = 8'h33;  6'd47: b = 8'h3e;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic type_lookup_t lookup_type(input logic [BYTE_W-1:0] code);
        type_lookup_t r;
        r.ok = 1'b1;
        case (code)
            8'h00, 8'h08, 8'h09:                      r.kind = MK_PLAIN;
            8'h01, 8'h02, 8'h03:                      r.kind = MK_MBC1;
            8'h05, 8'h06:                             r.kind = MK_MBC2;
            8'h0b, 8'h0c, 8'h0d:                      r.kind = MK_MMM01;
            8'h0f, 8'h10, 8'h11, 8'h12, 8'h13:        r.kind = MK_MBC3;
            8'h19, 8'h1a, 8'h1b, 8'h1c, 8'h1d, 8'h1e: r.kind = MK_MBC5;
            default:
            begin
                r.ok   = 1'b0;
                r.kind = MK_PLAIN;
            end
        endcase
        return r;
    endfunction

endpackage

>>> rtl/core/chv_if.sv
// Stream interfaces for header bytes in and verdicts out.
interface chv_in_if;
    logic                          valid;
    logic                          ready;
    logic [chv_pkg::OFFSET_W-1:0]  offset;
    logic [chv_pkg::BYTE_W-1:0]    data_byte;

    modport source (output valid, output offset, output data_byte, input ready);
    modport sink   (input valid, input offset, input data_byte, output ready);
endinterface

interface chv_out_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    status;
    logic [2:0]                    mapper_kind;
    logic [chv_pkg::BYTE_W-1:0]    type_code;
    logic                          japan_region;
    logic [chv_pkg::BYTE_W-1:0]    version_byte;
    logic [chv_pkg::BYTE_W-1:0]    computed_sum;
    logic [chv_pkg::BYTE_W-1:0]    stored_sum;

    modport source (output valid, output status, output mapper_kind, output type_code,
                    output japan_region, output version_byte, output computed_sum,
                    output stored_sum, input ready);
    modport sink   (input valid, input status, input mapper_kind, input type_code,
                    input japan_region, input version_byte, input computed_sum,
                    input stored_sum, output ready);
endinterface

>>> rtl/core/cartridge_header_validator_unit.sv
// Cartridge header validator: logo compare, type lookup, checksum and verdict register.
// The verdict is valid in the cycle after the word at offset 0x14d is accepted.
// Throughput: one header word per cycle while in.ready is high; each word updates the header state directly.
// in.ready drops only while a verdict sits in the output register and out.ready is low.
// Reset (async, active low): empties the verdict register, sets logo match, clears sums.
// State also returns to its reset values at each verdict, ready for the next header.
module cartridge_header_validator_unit (
    input  logic     clk,
    input  logic     rst_n,
    chv_in_if.sink   in_ch,
    chv_out_if.source out_ch
);
    import chv_pkg::*;

    logic                logo_ok_reg,   logo_ok_next;
    logic [BYTE_W-1:0]   sum_reg,       sum_next;
    logic [BYTE_W-1:0]   type_reg,      type_next;
    logic                region_reg,    region_next;
    logic [BYTE_W-1:0]   version_reg,   version_next;

    logic                out_valid_reg;
    status_t             status_reg,    status_next;
    mapper_kind_t        kind_reg;
    logic [BYTE_W-1:0]   otype_reg;
    logic                ojapan_reg;
    logic [BYTE_W-1:0]   oversion_reg;
    logic [BYTE_W-1:0]   ocomp_reg;
    logic [BYTE_W-1:0]   ostored_reg;

    logic                in_fire;
    logic                in_logo, in_sum, in_stored;
    logic [5:0]          logo_idx;
    type_lookup_t        type_info;

    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign in_fire     = in_ch.valid && in_ch.ready;

    assign in_logo   = (in_ch.offset >= LOGO_START) && (in_ch.offset <= LOGO_END);
    assign in_sum    = (in_ch.offset >= SUM_START) && (in_ch.offset <= VERSION_AT);
    assign in_stored = (in_ch.offset == STORED_AT);
    assign logo_idx  = 6'(in_ch.offset - LOGO_START);
    assign type_info = lookup_type(type_reg);

    always_comb
    begin
        logo_ok_next = logo_ok_reg;
        sum_next     = sum_reg;
        type_next    = type_reg;
        region_next  = region_reg;
        version_next = version_reg;
        if (in_logo)
        begin
            if (logo_byte(logo_idx) != in_ch.data_byte)
            begin
                logo_ok_next = 1'b0;
            end
        end
        else if (in_sum)
        begin
            // accumulator loses (byte + 1) mod 256
            sum_next = sum_reg - in_ch.data_byte - 8'd1;
            if (in_ch.offset == TYPE_AT)
            begin
                type_next = in_ch.data_byte;
            end
            else if (in_ch.offset == REGION_AT)
            begin
                region_next = (in_ch.data_byte == 8'h00);
            end
            else if (in_ch.offset == VERSION_AT)
            begin
                version_next = in_ch.data_byte;
            end
        end
        else if (in_stored)
        begin
            logo_ok_next = 1'b1;
            sum_next     = '0;
            type_next    = '0;
            region_next  = 1'b0;
            version_next = '0;
        end
    end

    always_comb
    begin
        if (!logo_ok_reg)
        begin
            status_next = ST_BAD_LOGO;
        end
        else if (!type_info.ok)
        begin
            status_next = ST_BAD_TYPE;
        end
        else if (sum_reg != in_ch.data_byte)
        begin
            status_next = ST_BAD_SUM;
        end
        else
        begin
            status_next = ST_VALID;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            logo_ok_reg   <= 1'b1;
            sum_reg       <= '0;
            type_reg      <= '0;
            region_reg    <= 1'b0;
            version_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                logo_ok_reg <= logo_ok_next;
                sum_reg     <= sum_next;
                type_reg    <= type_next;
                region_reg  <= region_next;
                version_reg <= version_next;
            end
            if (in_fire && in_stored)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && in_stored)
        begin
            status_reg   <= status_next;
            kind_reg     <= type_info.kind;
            otype_reg    <= type_reg;
            ojapan_reg   <= region_reg;
            oversion_reg <= version_reg;
            ocomp_reg    <= sum_reg;
            ostored_reg  <= in_ch.data_byte;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.status       = status_reg;
    assign out_ch.mapper_kind  = kind_reg;
    assign out_ch.type_code    = otype_reg;
    assign out_ch.japan_region = ojapan_reg;
    assign out_ch.version_byte = oversion_reg;
    assign out_ch.computed_sum = ocomp_reg;
    assign out_ch.stored_sum   = ostored_reg;

    // header state is back at reset values after a verdict word
    a_clear_after_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && in_stored) |=> (logo_ok_reg && sum_reg == '0 && type_reg == '0))
        else $error("header state not cleared after verdict");

    // a new verdict only appears after a checksum word was taken
    a_verdict_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(in_fire && in_stored))
        else $error("verdict without checksum word");

    a_valid_sum_match: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg == ST_VALID) |-> (ocomp_reg == ostored_reg))
        else $error("valid status with checksum mismatch");

    a_bad_type_plain: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg == ST_BAD_TYPE) |-> (kind_reg == MK_PLAIN))
        else $error("unsupported type with nonzero mapper kind");

    // nothing is accepted while a stalled verdict is held
    a_no_accept_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ch.ready) |-> !in_ch.ready)
        else $error("input accepted while verdict stalled");

endmodule
